// ===== hw/rtl/clt_pkg.sv =====
// clt_pkg: shared types and codes for the cell lifecycle table
// cell key, lifecycle phase and operation codes, table write control word
// no dependencies
package clt_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int TIME_W          = 48;
    localparam int DELAY_W         = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        PH_UNLOADED = 3'd0,
        PH_LOADING  = 3'd1,
        PH_LOADED   = 3'd2,
        PH_ACTIVE   = 3'd3,
        PH_SLEEPING = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_MARK     = 3'd1,
        OP_ACTIVATE = 3'd2,
        OP_SLEEP    = 3'd3,
        OP_UNLOAD   = 3'd4,
        OP_QUERY    = 3'd5
    } op_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  level;
        logic [15:0] z;
    } key_t;

    // one update to the table, applied at the clock edge
    typedef struct packed {
        logic              alloc;        // take the lowest free entry as loading
        logic              free_en;      // free the matching entry
        logic              phase_we;     // write phase of the matching entry
        logic              deadline_we;  // write deadline of the matching entry
        phase_t            phase;
        logic [TIME_W-1:0] deadline;
    } wr_ctl_t;

    typedef struct packed {
        logic              hit;
        logic              any_free;
        phase_t            phase;
        logic [TIME_W-1:0] deadline;
    } lookup_t;

endpackage

// ===== hw/rtl/clt_lookup.sv =====
// clt_lookup: parallel key compare and free-entry search over the table
// picks the lowest matching and lowest free entry as one-hot selects
// depends on clt_pkg
module clt_lookup
    import clt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
)
(
    input  key_t                     key,
    input  logic [TABLE_ENTRIES-1:0] valid,
    input  key_t                     keys      [TABLE_ENTRIES],
    input  phase_t                   phases    [TABLE_ENTRIES],
    input  logic [TIME_W-1:0]        deadlines [TABLE_ENTRIES],
    output logic [TABLE_ENTRIES-1:0] hit_sel,
    output logic [TABLE_ENTRIES-1:0] free_sel,
    output lookup_t                  info
);

    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] empty;
    logic [2:0]               phase_or;
    logic [TIME_W-1:0]        deadline_or;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match[i] = valid[i] && (keys[i] == key);
        end
    end

    assign empty    = ~valid;
    // isolate lowest set bit
    assign hit_sel  = match & (~match + TABLE_ENTRIES'(1));
    assign free_sel = empty & (~empty + TABLE_ENTRIES'(1));

    always_comb
    begin
        phase_or    = '0;
        deadline_or = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            phase_or    = phase_or    | ({3{hit_sel[i]}} & phases[i]);
            deadline_or = deadline_or | ({TIME_W{hit_sel[i]}} & deadlines[i]);
        end
    end

    always_comb
    begin
        info.hit      = |match;
        info.any_free = |empty;
        info.phase    = info.hit ? phase_t'(phase_or) : PH_UNLOADED;
        info.deadline = deadline_or;
    end

endmodule

// ===== hw/rtl/clt_table.sv =====
// clt_table: entry storage of the cell lifecycle table, in flip-flops
// valid bits are reset, key, phase and deadline are written on allocation or update
// depends on clt_pkg
module clt_table
    import clt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  wr_ctl_t                  ctl,
    input  key_t                     key,
    input  logic [TABLE_ENTRIES-1:0] hit_sel,
    input  logic [TABLE_ENTRIES-1:0] free_sel,
    output logic [TABLE_ENTRIES-1:0] valid,
    output key_t                     keys      [TABLE_ENTRIES],
    output phase_t                   phases    [TABLE_ENTRIES],
    output logic [TIME_W-1:0]        deadlines [TABLE_ENTRIES]
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    key_t                     key_reg      [TABLE_ENTRIES];
    phase_t                   phase_reg    [TABLE_ENTRIES];
    logic [TIME_W-1:0]        deadline_reg [TABLE_ENTRIES];

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.alloc)
        begin
            valid_next = valid_next | free_sel;
        end
        if (ctl.free_en)
        begin
            valid_next = valid_next & ~hit_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (ctl.alloc && free_sel[i])
            begin
                key_reg[i]   <= key;
                phase_reg[i] <= PH_LOADING;
            end
            else if (ctl.phase_we && hit_sel[i])
            begin
                phase_reg[i] <= ctl.phase;
            end
            if (ctl.deadline_we && hit_sel[i])
            begin
                deadline_reg[i] <= ctl.deadline;
            end
        end
    end

    assign valid     = valid_reg;
    assign keys      = key_reg;
    assign phases    = phase_reg;
    assign deadlines = deadline_reg;

    a_alloc_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc |-> $onehot(free_sel))
        else $error("allocation without a free entry");

    a_update_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.free_en || ctl.phase_we || ctl.deadline_we) |-> $onehot(hit_sel))
        else $error("entry update without a matching entry");

    a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.free_en |=> ((valid_reg & $past(hit_sel)) == '0))
        else $error("freed entry still valid");

endmodule

// ===== hw/rtl/cell_lifecycle_table.sv =====
// cell_lifecycle_table: top level of the keyed cell lifecycle table
// request register, lifecycle decision and result register around the entry table
// depends on clt_pkg, clt_lookup, clt_table
//
// usage
//   a request word (operation, cell key, now_time, unload_delay) is taken at a
//   rising edge with start high and busy low; busy is never raised, so one
//   request can be issued every cycle
//   the word is registered, then compared against all entries in parallel and
//   the lifecycle step is applied to the table at the following edge
//   the result word (accepted, cell_state, table_full) is registered at the
//   edge that applies the lifecycle step and appears on the result ports with
//   result_valid high; it stays for one cycle;
//   throughput is one request per cycle, set by the single
//   read-modify-write of the table per cycle
//   a request sees every table update made by the requests before it
//   the receiver cannot stall: each result is present for exactly one cycle
//   reset empties the table (all cells read as unloaded) and drops any
//   request or result in flight
module cell_lifecycle_table
    import clt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] cell_x,
    input  logic signed [31:0] cell_y,
    input  logic [7:0]         cell_level,
    input  logic signed [15:0] cell_z,
    input  logic [47:0]        now_time,
    input  logic [31:0]        unload_delay,
    output logic               result_valid,
    output logic               accepted,
    output logic [2:0]         cell_state,
    output logic               table_full
);

    logic               req_valid_reg;
    logic [2:0]         op_reg;
    key_t               key_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [DELAY_W-1:0] delay_reg;

    logic               result_valid_reg;
    logic               accepted_reg;
    phase_t             state_reg;
    logic               full_reg;

    logic               accepted_next;
    phase_t             state_next;
    logic               full_next;
    wr_ctl_t            ctl;
    logic [TIME_W:0]    deadline_sum;

    logic [TABLE_ENTRIES-1:0] valid;
    key_t                     keys      [TABLE_ENTRIES];
    phase_t                   phases    [TABLE_ENTRIES];
    logic [TIME_W-1:0]        deadlines [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit_sel;
    logic [TABLE_ENTRIES-1:0] free_sel;
    lookup_t                  info;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= operation;
            key_reg   <= '{x: cell_x, y: cell_y, level: cell_level, z: cell_z};
            now_reg   <= now_time;
            delay_reg <= unload_delay;
        end
    end

    clt_lookup #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_lookup (
        .key       (key_reg),
        .valid     (valid),
        .keys      (keys),
        .phases    (phases),
        .deadlines (deadlines),
        .hit_sel   (hit_sel),
        .free_sel  (free_sel),
        .info      (info)
    );

    // sleep deadline saturates at the top of the time range
    assign deadline_sum = {1'b0, now_reg} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_reg};

    always_comb
    begin
        accepted_next   = 1'b0;
        full_next       = 1'b0;
        state_next      = info.phase;
        ctl.alloc       = 1'b0;
        ctl.free_en     = 1'b0;
        ctl.phase_we    = 1'b0;
        ctl.deadline_we = 1'b0;
        ctl.phase       = info.phase;
        ctl.deadline    = deadline_sum[TIME_W] ? TIME_MAX : deadline_sum[TIME_W-1:0];
        case (op_t'(op_reg))
            OP_LOAD:
            begin
                if (!info.hit)
                begin
                    if (info.any_free)
                    begin
                        ctl.alloc     = 1'b1;
                        state_next    = PH_LOADING;
                        accepted_next = 1'b1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            OP_MARK:
            begin
                if (info.hit && info.phase == PH_LOADING)
                begin
                    state_next    = PH_LOADED;
                    accepted_next = 1'b1;
                end
            end
            OP_ACTIVATE:
            begin
                if (info.hit && info.phase inside {PH_LOADED, PH_SLEEPING})
                begin
                    state_next    = PH_ACTIVE;
                    accepted_next = 1'b1;
                end
            end
            OP_SLEEP:
            begin
                if (info.hit && info.phase == PH_ACTIVE)
                begin
                    state_next      = PH_SLEEPING;
                    accepted_next   = 1'b1;
                    ctl.deadline_we = 1'b1;
                end
            end
            OP_UNLOAD:
            begin
                if (info.hit && info.phase == PH_SLEEPING && now_reg >= info.deadline)
                begin
                    state_next    = PH_UNLOADED;
                    accepted_next = 1'b1;
                    ctl.free_en   = 1'b1;
                end
            end
            default:
            begin
                // query and unused codes report only
            end
        endcase
        if (!req_valid_reg)
        begin
            ctl.alloc       = 1'b0;
            ctl.free_en     = 1'b0;
            ctl.deadline_we = 1'b0;
            accepted_next   = 1'b0;
        end
        ctl.phase_we = accepted_next && info.hit && !ctl.free_en;
        ctl.phase    = state_next;
    end

    clt_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .key       (key_reg),
        .hit_sel   (hit_sel),
        .free_sel  (free_sel),
        .valid     (valid),
        .keys      (keys),
        .phases    (phases),
        .deadlines (deadlines)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        state_reg    <= state_next;
        full_reg     <= full_next;
    end

    assign result_valid = result_valid_reg;
    assign accepted     = accepted_reg;
    assign cell_state   = state_reg;
    assign table_full   = full_reg;

    a_one_result_per_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |=> result_valid_reg)
        else $error("request without a result");

    a_full_is_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && full_reg) |-> (!accepted_reg && state_reg == PH_UNLOADED))
        else $error("full table result reports an accepted step");

    a_query_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && op_reg == OP_QUERY) |=> !accepted_reg)
        else $error("query reported as accepted");

    a_full_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && full_next) |-> (op_reg == OP_LOAD && !info.any_free))
        else $error("table full flagged outside a load with no free entry");

endmodule
